/* hw/rtl/signed_fixed_point_multiplier_macros.svh */
// Assertion macros shared by the multiplier RTL.
`ifndef SIGNED_FIXED_POINT_MULTIPLIER_MACROS_SVH
`define SIGNED_FIXED_POINT_MULTIPLIER_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication, checked out of reset.
`define SFPM_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("sfpm check failed");
// Next-cycle implication, checked out of reset.
`define SFPM_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("sfpm check failed");
`else
`define SFPM_ASSERT_IMP(lbl, ante, cons)
`define SFPM_ASSERT_NXT(lbl, ante, cons)
`endif

`endif

/* hw/rtl/sfpm_pkg.sv */
package sfpm_pkg;

	localparam int unsigned NUM_W    = 132;
	localparam int unsigned FRAC_W   = 4;
	localparam int unsigned WORD_W   = 64;
	localparam int unsigned LIMB_W   = 32;
	localparam int unsigned NUM_LIMB = 5;
	localparam int unsigned EXT_W    = NUM_LIMB * LIMB_W;
	localparam int unsigned MAG_W    = NUM_W - FRAC_W;
	// limb pairs whose product lands below bit 132
	localparam int unsigned NUM_PAIR = NUM_LIMB * (NUM_LIMB + 1) / 2;

	typedef logic [NUM_W-1:0] num_t;

	// one item as it travels along the cell row
	typedef struct packed {
		logic vld;
		logic neg;
		num_t a;
		num_t b;
		num_t acc;
		num_t pp;
	} sfpm_bus_t;

	function automatic int unsigned pair_i(input int unsigned k);
		int unsigned n;
		int unsigned r;
		n = 0;
		r = 0;
		for (int unsigned i = 0; i < NUM_LIMB; i++) begin
			for (int unsigned j = 0; i + j < NUM_LIMB; j++) begin
				if (n == k) r = i;
				n++;
			end
		end
		return r;
	endfunction

	function automatic int unsigned pair_j(input int unsigned k);
		int unsigned n;
		int unsigned r;
		n = 0;
		r = 0;
		for (int unsigned i = 0; i < NUM_LIMB; i++) begin
			for (int unsigned j = 0; i + j < NUM_LIMB; j++) begin
				if (n == k) r = j;
				n++;
			end
		end
		return r;
	endfunction

endpackage

/* hw/rtl/signed_fixed_point_multiplier.sv */
// Signed Q128.4 multiplier: 132-bit two's-complement operands, 132-bit result.
// Command channel: drive the operand words and raise start; an item is taken at
// each rising edge with start high and busy low. busy stays low, so a new item
// may enter on every cycle.
// Result channel: done is high for exactly one cycle with prod_high, prod_low
// and prod_frac valid; the receiver must take it then, it cannot stall.
// A front register holds the operand magnitudes, fifteen cells each form one
// 32x32 limb product and fold the previous one into the running sum, and the
// tail adds the last product, registers the sum with the fraction truncated,
// then registers the result with the sign applied.
// Throughput: one item per cycle, set by the row of single-multiplier cells.
// Product bits from 132 upwards are dropped; no overflow flag is raised.
// Reset clears every valid flag at once; items in flight are lost and no done
// follows for them. Payload registers are not reset.
`include "signed_fixed_point_multiplier_macros.svh"

module signed_fixed_point_multiplier (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                busy,
	input  logic signed [63:0]  a_high,
	input  logic [63:0]         a_low,
	input  logic [3:0]          a_frac,
	input  logic signed [63:0]  b_high,
	input  logic [63:0]         b_low,
	input  logic [3:0]          b_frac,
	output logic                done,
	output logic signed [63:0]  prod_high,
	output logic [63:0]         prod_low,
	output logic [3:0]          prod_frac
);
	import sfpm_pkg::*;

	localparam int unsigned LAT = 1 + NUM_PAIR + 2;

	num_t      a_full;
	num_t      b_full;
	num_t      a_mag;
	num_t      b_mag;
	logic      take;
	sfpm_bus_t front_s1;
	sfpm_bus_t chain [NUM_PAIR+1];
	num_t      res;

	// never held off: the row takes an item every cycle
	assign busy = 1'b0;
	assign take = start && !busy;

	// glue the words into one 132-bit number and take magnitudes
	always_comb begin
		a_full = {a_high, a_low, a_frac};
		b_full = {b_high, b_low, b_frac};
		a_mag  = a_full[NUM_W-1] ? (NUM_W'(0) - a_full) : a_full;
		b_mag  = b_full[NUM_W-1] ? (NUM_W'(0) - b_full) : b_full;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_s1.vld <= 1'b0;
		end else begin
			front_s1.vld <= take;
			front_s1.neg <= a_full[NUM_W-1] ^ b_full[NUM_W-1];
			front_s1.a   <= a_mag;
			front_s1.b   <= b_mag;
			front_s1.acc <= '0;
			front_s1.pp  <= '0;
		end
	end

	assign chain[0] = front_s1;

	// one cell per limb pair; each hands its product to the next
	for (genvar k = 0; k < NUM_PAIR; k++) begin : g_cell
		sfpm_cell #(
			.LI(pair_i(k)),
			.LJ(pair_j(k))
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.bus_in (chain[k]),
			.bus_out(chain[k+1])
		);
	end

	sfpm_tail u_tail (
		.clk   (clk),
		.arst_n(arst_n),
		.bus_in(chain[NUM_PAIR]),
		.vld   (done),
		.res   (res)
	);

	assign prod_high = res[NUM_W-1 -: WORD_W];
	assign prod_low  = res[FRAC_W +: WORD_W];
	assign prod_frac = res[FRAC_W-1:0];

	// an accepted item enters the row on the next edge
	`SFPM_ASSERT_NXT(a_enter, take, front_s1.vld)
	// every result stems from an accepted item
	`SFPM_ASSERT_IMP(a_origin, done, $past(take, LAT))
	// two non-negative operands never give a negative product
	`SFPM_ASSERT_IMP(a_pos, done && !$past(a_high[63], LAT) && !$past(b_high[63], LAT),
		!prod_high[63])
	// a zero operand gives zero
	`SFPM_ASSERT_IMP(a_zero, done && $past(a_high == 64'd0 && a_low == 64'd0 && a_frac == 4'd0, LAT),
		prod_high == 64'd0 && prod_low == 64'd0 && prod_frac == 4'd0)

endmodule

/* hw/rtl/sfpm_cell.sv */
module sfpm_cell #(
	parameter int unsigned LI = 0,
	parameter int unsigned LJ = 0
) (
	input  logic               clk,
	input  logic               arst_n,
	input  sfpm_pkg::sfpm_bus_t bus_in,
	output sfpm_pkg::sfpm_bus_t bus_out
);
	import sfpm_pkg::*;

	logic [EXT_W-1:0]    a_ext;
	logic [EXT_W-1:0]    b_ext;
	logic [LIMB_W-1:0]   la;
	logic [LIMB_W-1:0]   lb;
	logic [2*LIMB_W-1:0] mul;
	logic [EXT_W-1:0]    mul_sh;
	sfpm_bus_t           bus_q;

	always_comb begin
		a_ext  = EXT_W'(bus_in.a);
		b_ext  = EXT_W'(bus_in.b);
		la     = a_ext[LI*LIMB_W +: LIMB_W];
		lb     = b_ext[LJ*LIMB_W +: LIMB_W];
		mul    = {{LIMB_W{1'b0}}, la} * {{LIMB_W{1'b0}}, lb};
		mul_sh = EXT_W'(mul) << (LIMB_W * (LI + LJ));
	end

	// fold in the neighbour's product, form our own
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bus_q.vld <= 1'b0;
		end else begin
			bus_q.vld <= bus_in.vld;
			bus_q.neg <= bus_in.neg;
			bus_q.a   <= bus_in.a;
			bus_q.b   <= bus_in.b;
			bus_q.acc <= bus_in.acc + bus_in.pp;
			bus_q.pp  <= mul_sh[NUM_W-1:0];
		end
	end

	assign bus_out = bus_q;

endmodule

/* hw/rtl/sfpm_tail.sv */
module sfpm_tail (
	input  logic                   clk,
	input  logic                   arst_n,
	input  sfpm_pkg::sfpm_bus_t    bus_in,
	output logic                   vld,
	output sfpm_pkg::num_t         res
);
	import sfpm_pkg::*;

	num_t             sum;
	logic [MAG_W-1:0] mag_s1;
	logic             neg_s1;
	logic             vld_s1;
	num_t             res_s2;
	logic             vld_s2;

	assign sum = bus_in.acc + bus_in.pp;

	// drop the four lowest product bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= bus_in.vld;
			mag_s1 <= sum[NUM_W-1:FRAC_W];
			neg_s1 <= bus_in.neg;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2 <= 1'b0;
		end else begin
			vld_s2 <= vld_s1;
			res_s2 <= neg_s1 ? (NUM_W'(0) - NUM_W'(mag_s1)) : NUM_W'(mag_s1);
		end
	end

	assign vld = vld_s2;
	assign res = res_s2;

endmodule
